// ----- rtl/core/ocpc_pkg.sv -----
// Package for the omni chassis position controller core: register indexes,
// mode codes, multiplier types and the quarter-wave sine table. No dependencies.
`timescale 1ns / 1ps
package ocpc_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int QDEPTH = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W = SIDX_W - 2;
    localparam int QMAG_W = 17;

    localparam logic [2:0] CFG_POS_GAIN   = 3'd0;
    localparam logic [2:0] CFG_POS_LIM    = 3'd1;
    localparam logic [2:0] CFG_HDG_GAIN   = 3'd2;
    localparam logic [2:0] CFG_HDG_LIM    = 3'd3;
    localparam logic [2:0] CFG_LIN_LIM    = 3'd4;
    localparam logic [2:0] CFG_TURN_LIM   = 3'd5;
    localparam logic [2:0] CFG_RADIUS     = 3'd6;

    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_CAL   = 3'd1;
    localparam logic [2:0] MODE_MAN   = 3'd2;
    localparam logic [2:0] MODE_POS   = 3'd3;

    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
    localparam logic [31:0] K0866 = 32'd56753;
    localparam logic [31:0] K05   = 32'd32768;

    // operand select codes for the shared multiplier
    typedef enum logic [3:0] {
        OP_EX, OP_EY, OP_PH, OP_C_OX, OP_S_OY, OP_C_OY, OP_S_OX, OP_EH,
        OP_RT, OP_VX, OP_VY
    } t_op;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    // Q30 quarter sine by Horner series, used to build the table at elaboration
    function automatic longint unsigned quarter_sine(longint unsigned r);
        longint unsigned t, t2, u;
        t  = (r * 64'd1686629713) >> 30;
        t2 = (t * t) >> 30;
        u  = 64'd1073741824;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 110;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 72;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 42;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 20;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 6;
        return (t * u) >> 30;
    endfunction

    function automatic logic signed [31:0] sine_entry(logic [SIDX_W-1:0] idx);
        longint unsigned p, q, r, s;
        longint v;
        p = (longint'(idx) << 32) / SINE_TABLE_DEPTH;
        q = (p >> 30) & 3;
        r = p & 64'h3FFF_FFFF;
        if (q[0]) r = 64'd1073741824 - r;
        s = quarter_sine(r);
        v = longint'((s + 8192) >> 14);
        if (q[1]) v = -v;
        return 32'(v);
    endfunction

    // magnitudes of the first quarter turn, entry j at j * QMAG_W
    function automatic logic [QDEPTH*QMAG_W-1:0] build_qtab();
        logic [QDEPTH*QMAG_W-1:0] tab;
        tab = '0;
        for (int j = 0; j < QDEPTH; j++)
            tab[j*QMAG_W +: QMAG_W] = QMAG_W'(sine_entry(SIDX_W'(j)));
        return tab;
    endfunction

    localparam logic [QDEPTH*QMAG_W-1:0] SINE_QTAB = build_qtab();
    // value at exactly one quarter turn
    localparam logic [QMAG_W-1:0] SINE_PEAK = QMAG_W'(sine_entry(SIDX_W'(QDEPTH)));

endpackage

// ----- rtl/core/ocpc_mul.sv -----
// Shared multi-cycle signed multiplier: 64x64 product from 32x32 partials.
// Depends on ocpc_pkg.
`timescale 1ns / 1ps
module ocpc_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ocpc_pkg::t_mul_req      i_req,
    output logic                    o_done,
    output logic signed [63:0]      o_prod
);
    import ocpc_pkg::*;

    logic [1:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [63:0] r_a, r_b;
    logic [63:0] r_acc, n_acc;
    logic        r_neg;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    // unsigned magnitudes, three 32x32 partials accumulated, sign applied at the end
    always_comb begin
        w_x = r_step[1] ? r_a[63:32] : r_a[31:0];
        w_y = r_step[0] ? r_b[63:32] : r_b[31:0];
        w_pp = 64'(w_x) * 64'(w_y);
        n_busy = r_busy;
        n_step = r_step;
        n_acc  = r_acc;
        if (r_busy) begin
            case (r_step)
                2'd0: n_acc = r_acc + w_pp;
                2'd1: n_acc = r_acc + (w_pp << 32);
                2'd2: n_acc = r_acc + (w_pp << 32);
                default: n_acc = r_acc;
            endcase
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_step == 2'd3);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else begin
                r_busy <= n_busy;
                r_step <= n_step;
            end
        end
        if (i_req.start) begin
            r_a   <= i_req.a[63] ? -i_req.a : i_req.a;
            r_b   <= i_req.b[63] ? -i_req.b : i_req.b;
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_acc <= 64'd0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);
endmodule

// ----- rtl/core/omni_chassis_position_controller_core.sv -----
// Omni chassis position controller: mode handling, P loops, yaw rotation and
// three-wheel map, all products through one shared multiplier. A position-mode
// beat takes 11 products and a sine/cosine table lookup, other modes three, before
// the output state. A new beat is taken only when idle, after the previous result
// is registered; the output state holds while a result beat waits.
// Sync active-low reset restores defaults and clears held state.
`timescale 1ns / 1ps
module omni_chassis_position_controller_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_drive_mode,
    input  logic signed [31:0] i_meas_x,
    input  logic signed [31:0] i_meas_y,
    input  logic signed [31:0] i_meas_heading,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [31:0] i_goal_heading,
    input  logic signed [31:0] i_cmd_vx,
    input  logic signed [31:0] i_cmd_vy,
    input  logic signed [31:0] i_cmd_turn,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_wheel_a_speed,
    output logic signed [31:0] o_wheel_b_speed,
    output logic signed [31:0] o_wheel_c_speed
);
    import ocpc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH, ST_OUT
    } t_state;

    // configuration registers
    logic [23:0] r_pos_gain, r_hdg_gain, r_radius;
    logic [30:0] r_pos_lim, r_hdg_lim, r_lin_lim, r_turn_lim;

    // held state
    logic signed [31:0] r_gx, r_gy, r_gh, r_vx, r_vy, r_turn;

    // captured measurement
    logic signed [31:0] r_mx, r_my, r_mh;

    t_state             r_state;
    t_op                r_op;
    logic signed [31:0] r_ox, r_oy, r_sn, r_cs;
    logic signed [63:0] r_acc;
    logic [SIDX_W-1:0]  r_sidx, r_cidx;

    t_mul_req           w_req;
    logic               w_done;
    logic signed [63:0] w_prod;

    ocpc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    function automatic logic signed [63:0] sx(logic signed [31:0] v);
        return 64'(v);
    endfunction

    function automatic logic signed [63:0] ux(logic [30:0] v);
        return {33'd0, v};
    endfunction

    // round half up back to Q16.16 (wide)
    function automatic logic signed [63:0] rnd16(logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [63:0] v, logic [30:0] lim);
        logic signed [63:0] l;
        l = ux(lim);
        if (v > l) return 32'(l);
        if (v < -l) return 32'(-l);
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // full-turn sine from the quarter-wave table: mirror odd quarters, negate the
    // second half turn
    function automatic logic signed [31:0] sine_lookup(logic [SIDX_W-1:0] idx);
        logic [QIDX_W:0]    k;
        logic [QMAG_W-1:0]  mag;
        logic signed [31:0] m;
        k = {1'b0, idx[QIDX_W-1:0]};
        if (idx[QIDX_W]) k = (QIDX_W+1)'(QDEPTH) - k;
        if (k[QIDX_W]) mag = SINE_PEAK;
        else mag = SINE_QTAB[k[QIDX_W-1:0]*QMAG_W +: QMAG_W];
        m = 32'(mag);
        return idx[SIDX_W-1] ? -m : m;
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        w_req.start = (r_state == ST_ISSUE);
        w_req.a = 64'd0;
        w_req.b = 64'd0;
        case (r_op)
            OP_EX:   begin w_req.a = {40'd0, r_pos_gain}; w_req.b = sx(r_gx) - sx(r_mx); end
            OP_EY:   begin w_req.a = {40'd0, r_pos_gain}; w_req.b = sx(r_gy) - sx(r_my); end
            OP_PH:   begin w_req.a = sx(r_mh); w_req.b = {32'd0, TURN_PER_RAD}; end
            OP_C_OX: begin w_req.a = sx(r_cs); w_req.b = sx(r_ox); end
            OP_S_OY: begin w_req.a = sx(r_sn); w_req.b = sx(r_oy); end
            OP_C_OY: begin w_req.a = sx(r_cs); w_req.b = sx(r_oy); end
            OP_S_OX: begin w_req.a = sx(r_sn); w_req.b = sx(r_ox); end
            OP_EH:   begin w_req.a = {40'd0, r_hdg_gain}; w_req.b = sx(r_gh) - sx(r_mh); end
            OP_RT:   begin w_req.a = sx(r_turn); w_req.b = {40'd0, r_radius}; end
            OP_VX:   begin w_req.a = sx(r_vx); w_req.b = {32'd0, K0866}; end
            OP_VY:   begin w_req.a = sx(r_vy); w_req.b = {32'd0, K05}; end
            default: begin w_req.a = 64'd0; w_req.b = 64'd0; end
        endcase
    end

    // take no beat while reset is held
    assign o_ready = (r_state == ST_IDLE) && i_rst_n;

    logic [31:0] w_phase;
    assign w_phase = w_prod[47:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_gain <= 24'd32768;
            r_pos_lim  <= 31'd3276800;
            r_hdg_gain <= 24'd262144;
            r_hdg_lim  <= 31'd655360;
            r_lin_lim  <= 31'd58982;
            r_turn_lim <= 31'd262144;
            r_radius   <= 24'd9830;
            r_gx <= '0; r_gy <= '0; r_gh <= '0;
            r_vx <= '0; r_vy <= '0; r_turn <= '0;
            r_state <= ST_IDLE;
            r_op    <= OP_RT;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POS_GAIN: r_pos_gain <= i_cfg_data[23:0];
                    CFG_POS_LIM:  r_pos_lim  <= i_cfg_data;
                    CFG_HDG_GAIN: r_hdg_gain <= i_cfg_data[23:0];
                    CFG_HDG_LIM:  r_hdg_lim  <= i_cfg_data;
                    CFG_LIN_LIM:  r_lin_lim  <= i_cfg_data;
                    CFG_TURN_LIM: r_turn_lim <= i_cfg_data;
                    CFG_RADIUS:   r_radius   <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_mx <= i_meas_x; r_my <= i_meas_y; r_mh <= i_meas_heading;
                        r_op <= OP_RT;
                        case (i_drive_mode)
                            MODE_STOP: begin
                                r_gx <= '0; r_gy <= '0; r_gh <= '0;
                                r_vx <= '0; r_vy <= '0; r_turn <= '0;
                            end
                            MODE_CAL: begin
                                r_gx <= '0; r_gy <= '0; r_gh <= i_goal_heading;
                            end
                            MODE_MAN: begin
                                r_vx   <= sat32(sx(i_cmd_vx) * 64'sd2);
                                r_vy   <= sat32(sx(i_cmd_vy) * 64'sd2);
                                r_turn <= sat32(sx(i_cmd_turn) * 64'sd3);
                            end
                            MODE_POS: begin
                                r_gx <= i_goal_x; r_gy <= i_goal_y; r_gh <= i_goal_heading;
                                r_op <= OP_EX;
                            end
                            default: ;
                        endcase
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_done) begin
                        r_state <= ST_ISSUE;
                        case (r_op)
                            OP_EX: begin r_ox <= clamp(rnd16(w_prod), r_pos_lim); r_op <= OP_EY; end
                            OP_EY: begin r_oy <= clamp(rnd16(w_prod), r_pos_lim); r_op <= OP_PH; end
                            OP_PH: begin
                                r_sidx <= SIDX_W'((64'(w_phase) * SINE_TABLE_DEPTH) >> 32);
                                r_cidx <= SIDX_W'((64'(w_phase + 32'h4000_0000)
                                          * SINE_TABLE_DEPTH) >> 32);
                                r_state <= ST_FINISH;
                            end
                            OP_C_OX: begin r_acc <= w_prod; r_op <= OP_S_OY; end
                            OP_S_OY: begin
                                r_vx <= clamp(rnd16(r_acc + w_prod), r_lin_lim);
                                r_op <= OP_C_OY;
                            end
                            OP_C_OY: begin r_acc <= w_prod; r_op <= OP_S_OX; end
                            OP_S_OX: begin
                                r_vy <= clamp(rnd16(r_acc - w_prod), r_lin_lim);
                                r_op <= OP_EH;
                            end
                            OP_EH: begin
                                r_turn <= clamp(64'(clamp(rnd16(w_prod), r_hdg_lim)),
                                                r_turn_lim);
                                r_op <= OP_RT;
                            end
                            OP_RT: begin r_acc <= w_prod; r_op <= OP_VX; end
                            OP_VX: begin r_ox <= 32'(w_prod >>> 0); r_sn <= 32'(w_prod >>> 32);
                                         r_op <= OP_VY; end
                            OP_VY: begin r_oy <= 32'(w_prod); r_cs <= 32'(w_prod >>> 32);
                                         r_state <= ST_OUT; end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FINISH: begin
                    // table lookup for sin and cos
                    r_sn <= sine_lookup(r_sidx);
                    r_cs <= sine_lookup(r_cidx);
                    r_op <= OP_C_OX;
                    r_state <= ST_ISSUE;
                end
                ST_OUT: begin
                    // vx*K in {r_sn,r_ox}, vy*K05 in {r_cs,r_oy}, R*turn in r_acc
                    // hold here while the previous result beat still waits
                    if (!o_valid) begin
                        o_wheel_a_speed <= sat32(rnd16({r_sn, r_ox} - {r_cs, r_oy} - r_acc));
                        o_wheel_b_speed <= sat32(rnd16((sx(r_vy) <<< 16) - r_acc));
                        o_wheel_c_speed <= sat32(rnd16(-{r_sn, r_ox} - {r_cs, r_oy} - r_acc));
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end
endmodule

// ----- dv/tb_omni_chassis_position_controller_core.sv -----
// Testbench for the omni chassis position controller core: drives control ticks,
// predicts wheel speeds with its own fixed-point kinematics and checks each beat.
// Depends on ocpc_pkg and omni_chassis_position_controller_core.
`timescale 1ns / 1ps
module tb_omni_chassis_position_controller_core;
    import ocpc_pkg::*;

    typedef struct {
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
    } t_wheels;

    // Compare wheel beats against predicted wheel speeds, oldest first.
    class wheel_scoreboard;
        t_wheels pending[$];
        int      errors;

        function void note_tick(t_wheels w);
            pending.push_back(w);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_wheels(logic [31:0] a, logic [31:0] b, logic [31:0] c);
            t_wheels w;
            if (pending.size() == 0) begin
                report("wheel beat with nothing pending");
                return;
            end
            w = pending.pop_front();
            if (a !== w.wa || b !== w.wb || c !== w.wc)
                report($sformatf("wheels got %h %h %h want %h %h %h",
                                 a, b, c, w.wa, w.wb, w.wc));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_drive_mode = '0;
    logic signed [31:0] i_meas_x = 0, i_meas_y = 0, i_meas_heading = 0;
    logic signed [31:0] i_goal_x = 0, i_goal_y = 0, i_goal_heading = 0;
    logic signed [31:0] i_cmd_vx = 0, i_cmd_vy = 0, i_cmd_turn = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic signed [31:0] o_wheel_a_speed, o_wheel_b_speed, o_wheel_c_speed;

    omni_chassis_position_controller_core u_dut (.*);

    always #4 i_clk = ~i_clk;

    wheel_scoreboard sb = new();

    // predictor copy of registers and held state
    longint pos_gain, pos_lim, hdg_gain, hdg_lim, lin_lim, turn_lim, radius;
    longint hold_gx, hold_gy, hold_gh, hold_vx, hold_vy, hold_turn;
    longint sine_lut[SINE_TABLE_DEPTH];

    function automatic longint rnd_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q30 sine of one quarter turn, Horner series
    function automatic longint unsigned q30_sine(longint unsigned r);
        longint unsigned t, t2, u;
        longint unsigned one;
        one = 64'd1073741824;
        t  = (r * 64'd1686629713) >> 30;
        t2 = (t * t) >> 30;
        u  = one;
        u  = one - ((t2 * u) >> 30) / 110;
        u  = one - ((t2 * u) >> 30) / 72;
        u  = one - ((t2 * u) >> 30) / 42;
        u  = one - ((t2 * u) >> 30) / 20;
        u  = one - ((t2 * u) >> 30) / 6;
        return (t * u) >> 30;
    endfunction

    task automatic fill_sine_lut();
        longint unsigned p, q, r;
        longint v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            p = (longint'(i) << 32) / SINE_TABLE_DEPTH;
            q = (p >> 30) & 3;
            r = p & 64'h3FFF_FFFF;
            if (q[0]) r = 64'd1073741824 - r;
            v = longint'((q30_sine(r) + 8192) >> 14);
            sine_lut[i] = q[1] ? -v : v;
        end
    endtask

    function automatic longint lut_at(logic [31:0] phase);
        longint unsigned idx;
        idx = ({32'd0, phase} * SINE_TABLE_DEPTH) >> 32;
        return sine_lut[idx];
    endfunction

    task automatic reset_predictor();
        pos_gain = 32768; pos_lim = 3276800; hdg_gain = 262144; hdg_lim = 655360;
        lin_lim = 58982; turn_lim = 262144; radius = 9830;
        hold_gx = 0; hold_gy = 0; hold_gh = 0; hold_vx = 0; hold_vy = 0; hold_turn = 0;
    endtask

    // Advance held state for one tick and return the wheel speeds it yields.
    function automatic t_wheels predict_wheels(logic [2:0] mode,
            longint mx, longint my, longint mh, longint gx, longint gy, longint gh,
            longint cvx, longint cvy, longint ctn);
        t_wheels w;
        longint ox, oy, sn, cs, rt, a, b, c;
        logic [63:0] ph64;
        logic [31:0] phase;
        case (mode)
            MODE_STOP: begin
                hold_gx = 0; hold_gy = 0; hold_gh = 0;
                hold_vx = 0; hold_vy = 0; hold_turn = 0;
            end
            MODE_CAL: begin
                hold_gx = 0; hold_gy = 0; hold_gh = gh;
            end
            MODE_MAN: begin
                hold_vx = sat_s32(cvx * 2);
                hold_vy = sat_s32(cvy * 2);
                hold_turn = sat_s32(ctn * 3);
            end
            MODE_POS: begin
                hold_gx = gx; hold_gy = gy; hold_gh = gh;
                ox = clip(rnd_q16(pos_gain * (gx - mx)), pos_lim);
                oy = clip(rnd_q16(pos_gain * (gy - my)), pos_lim);
                ph64 = mh * longint'(TURN_PER_RAD);
                phase = ph64[47:16];
                sn = lut_at(phase);
                cs = lut_at(phase + 32'h4000_0000);
                hold_vx = clip(rnd_q16(cs * ox + sn * oy), lin_lim);
                hold_vy = clip(rnd_q16(cs * oy - sn * ox), lin_lim);
                hold_turn = clip(clip(rnd_q16(hdg_gain * (gh - mh)), hdg_lim), turn_lim);
            end
            default: ;
        endcase
        rt = hold_turn * radius;
        a = rnd_q16(hold_vx * longint'(K0866) - hold_vy * longint'(K05) - rt);
        b = rnd_q16(hold_vy * 65536 - rt);
        c = rnd_q16(-hold_vx * longint'(K0866) - hold_vy * longint'(K05) - rt);
        w.wa = 32'(sat_s32(a));
        w.wb = 32'(sat_s32(b));
        w.wc = 32'(sat_s32(c));
        return w;
    endfunction

    // Write one register while the block is idle.
    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_POS_GAIN: pos_gain = val[23:0];
            CFG_POS_LIM:  pos_lim  = val;
            CFG_HDG_GAIN: hdg_gain = val[23:0];
            CFG_HDG_LIM:  hdg_lim  = val;
            CFG_LIN_LIM:  lin_lim  = val;
            CFG_TURN_LIM: turn_lim = val;
            CFG_RADIUS:   radius   = val[23:0];
            default: ;
        endcase
    endtask

    // Drain: wait for every pending wheel beat, then let the core settle.
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    int burst_left = 0;

    // Send one tick; hold valid and payload until the beat is taken.
    task automatic send_tick(logic [2:0] mode, logic [31:0] mx, logic [31:0] my,
            logic [31:0] mh, logic [31:0] gx, logic [31:0] gy, logic [31:0] gh,
            logic [31:0] vx, logic [31:0] vy, logic [31:0] tn);
        // step off the edge that dropped valid for the previous beat
        @(posedge i_clk);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1; i_drive_mode <= mode;
        i_meas_x <= mx; i_meas_y <= my; i_meas_heading <= mh;
        i_goal_x <= gx; i_goal_y <= gy; i_goal_heading <= gh;
        i_cmd_vx <= vx; i_cmd_vy <= vy; i_cmd_turn <= tn;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_tick(predict_wheels(mode, signed'(mx), signed'(my), signed'(mh),
                     signed'(gx), signed'(gy), signed'(gh),
                     signed'(vx), signed'(vy), signed'(tn)));
        i_valid <= 0;
    endtask

    // Mostly small poses so the loops are not always clamped; sometimes full range.
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
        endcase
    endfunction

    task automatic random_ticks(int n);
        logic [2:0] mode;
        for (int k = 0; k < n; k++) begin
            mode = ($urandom_range(0, 9) < 5) ? MODE_POS : 3'($urandom_range(0, 7));
            send_tick(mode, pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                      pick_q16(), pick_q16(), pick_q16(), pick_q16());
        end
    endtask

    function automatic logic [30:0] pick_reg(logic [2:0] idx);
        logic [30:0] top;
        top = (idx == CFG_POS_GAIN || idx == CFG_HDG_GAIN || idx == CFG_RADIUS)
              ? 31'h00FF_FFFF : 31'h7FFF_FFFF;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return 31'($urandom) & top & 31'h003F_FFFF;
        endcase
    endfunction

    // Receiver: stall on its own pattern, with stall-free stretches.
    int rx_phase = 0;
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase[9:8] == 2'b01)
            i_ready <= 1;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
        if (i_rst_n && o_valid && i_ready)
            sb.check_wheels(o_wheel_a_speed, o_wheel_b_speed, o_wheel_c_speed);
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        fill_sine_lut();
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every mode, extremes of every field
        send_tick(MODE_MAN, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tick(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tick(MODE_MAN, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_tick(3'd7, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_tick(MODE_CAL, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0003_0000, 0, 0, 0);
        send_tick(3'd4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tick(MODE_STOP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 1, 1);
        send_tick(MODE_POS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        send_tick(MODE_POS, 0, 0, 32'h0001_921F, 32'h0001_0000, 32'hFFFF_0000,
                  32'hFFFE_0000, 0, 0, 0);
        send_tick(MODE_POS, 32'h0000_8000, 0, 32'hFFFC_0000, 0, 32'h0000_4000, 0, 0, 0, 0);
        send_tick(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // hold off until the core has drained at least once
        wait_drained();

        // zero limits force zero, then full scale registers, then random settings
        for (int r = 0; r < 7; r++) write_reg(3'(r), 0);
        write_reg(3'd7, 31'h1234);
        random_ticks(20);
        wait_drained();
        for (int r = 0; r < 7; r++) write_reg(3'(r), pick_reg(3'(r)) | 31'h7FFF_FFFF);
        send_tick(MODE_MAN, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        random_ticks(30);
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            for (int r = 0; r < 7; r++)
                if (ph == 0 || $urandom_range(0, 1)) write_reg(3'(r), pick_reg(3'(r)));
            random_ticks(210);
        end
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
